// ===== rtl/exs_pkg.sv =====
// ----------------------------------------------------------------------------
// exs_pkg: shared types for the exchange sorter
// Command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package exs_pkg;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // store or drop the accepted input word
    logic rd_q_sel;  // memory read address: 0 = p, 1 = q
    logic cur_load;  // take read data as the running minimum
    logic q_init;    // q <= p + 1
    logic cmp;       // compare read data with minimum, swap if smaller
    logic q_inc;     // q <= q + 1
    logic out_load;  // capture minimum into the output register
    logic p_inc;     // p <= p + 1
    logic done;      // list finished: clear count, drop flag and p
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_p;    // p is the final stored position
    logic last_q;    // q is the final stored position
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/exchange_sorter.sv =====
// ----------------------------------------------------------------------------
// exchange_sorter: collects a list of signed words and returns it ascending
// Exchange sort over a single-port-write element memory, emitting each
// position as soon as its minimum is settled.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o  value_i, last_i
//   out      output     out_valid_o / out_stall_i sorted_value_o, final_res_o,
//                                                overflow_o
//
// Loading accepts one word per cycle. After the last word, each position is
// scanned for its minimum, each scan step being a read on the memory's
// registered read port and then a compare, and is emitted before the next.
// Words beyond MAX_LEN are dropped and flagged. Input is stalled from the
// last word until the final result is taken. Reset is asynchronous; the
// memory needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module exchange_sorter #(
  parameter int MAX_LEN    = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] sorted_value_o,
  output logic                         final_res_o,
  output logic                         overflow_o
);

  exs_pkg::cmd_t cmd;
  exs_pkg::sts_t sts;

  exs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_i      (last_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  exs_dpath #(
    .MAX_LEN    (MAX_LEN),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .value_i        (value_i),
    .sorted_value_o (sorted_value_o),
    .final_res_o    (final_res_o),
    .overflow_o     (overflow_o)
  );

  // Never accepting input while a result is on offer
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("input open while result pending");

  // A last word closes the input side
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_i) |=> in_stall_o)
    else $error("input still open after last word");

  // Taking the final result reopens the input side
  a_final_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && final_res_o) |=> (!in_stall_o && !out_valid_o))
    else $error("input not reopened after final result");

endmodule

`default_nettype wire

// ===== rtl/exs_dpath.sv =====
// ----------------------------------------------------------------------------
// exs_dpath: exchange sorter datapath
// Element memory, fill count, drop flag, position counters, running minimum
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module exs_dpath #(
  parameter int MAX_LEN    = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  exs_pkg::cmd_t                cmd_i,
  output exs_pkg::sts_t                sts_o,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  output logic signed [DATA_WIDTH-1:0] sorted_value_o,
  output logic                         final_res_o,
  output logic                         overflow_o
);

  localparam int IW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  logic signed [DATA_WIDTH-1:0] mem [MAX_LEN];
  logic signed [DATA_WIDTH-1:0] rdata_q;
  logic signed [DATA_WIDTH-1:0] cur_d, cur_q;
  logic [CW-1:0]                count_d, count_q;
  logic                         drop_d, drop_q;
  logic [IW-1:0]                p_d, p_q, q_d, q_q;
  logic [IW-1:0]                rd_addr, wr_addr;
  logic                         wr_en;
  logic signed [DATA_WIDTH-1:0] wr_data;
  logic                         room;
  logic                         less;

  assign room = count_q < CW'(MAX_LEN);
  assign less = rdata_q < cur_q;

  // Status: compare positions against the fill count
  assign sts_o.last_p = (CW'(p_q) + CW'(1)) == count_q;
  assign sts_o.last_q = (CW'(q_q) + CW'(1)) == count_q;

  // Memory port selection
  assign rd_addr = cmd_i.rd_q_sel ? q_q : p_q;
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = q_q;
    wr_data = cur_q;
    if (cmd_i.load && room) begin
      wr_en   = 1'b1;
      wr_addr = count_q[IW-1:0];
      wr_data = value_i;
    end else if (cmd_i.cmp && less) begin
      wr_en = 1'b1;
    end
  end

  // Element memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  // Next-state logic for control registers and running minimum
  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    p_d     = p_q;
    q_d     = q_q;
    cur_d   = cur_q;
    if (cmd_i.load) begin
      if (room) begin
        count_d = count_q + CW'(1);
      end else begin
        drop_d = 1'b1;
      end
    end
    if (cmd_i.cur_load || (cmd_i.cmp && less)) begin
      cur_d = rdata_q;
    end
    if (cmd_i.q_init) begin
      q_d = p_q + IW'(1);
    end
    if (cmd_i.q_inc) begin
      q_d = q_q + IW'(1);
    end
    if (cmd_i.p_inc) begin
      p_d = p_q + IW'(1);
    end
    if (cmd_i.done) begin
      count_d = '0;
      drop_d  = 1'b0;
      p_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
      p_q     <= '0;
      q_q     <= '0;
    end else begin
      count_q <= count_d;
      drop_q  <= drop_d;
      p_q     <= p_d;
      q_q     <= q_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (cmd_i.out_load) begin
      sorted_value_o <= cur_q;
      final_res_o    <= sts_o.last_p;
      overflow_o     <= drop_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/exs_ctrl.sv =====
// ----------------------------------------------------------------------------
// exs_ctrl: exchange sorter controller
// Sequences load, the per-position minimum scan with swaps, and the output
// handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module exs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          last_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output exs_pkg::cmd_t cmd_o,
  input  exs_pkg::sts_t sts_i
);

  typedef enum logic [2:0] {
    S_LOAD,  // collecting words
    S_RDP,   // read position p
    S_WTP,   // take element p as the running minimum
    S_RDQ,   // read position q
    S_CMP,   // compare and swap
    S_EMIT,  // load the output register
    S_OUT    // wait for the word to be taken
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_d;
  logic   in_acc, out_acc;

  assign in_stall_o = state_q != S_LOAD;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;

  // Command decode and next state
  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_o;
    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          cmd_o.load = 1'b1;
          if (last_i) begin
            state_d = S_RDP;
          end
        end
      end
      S_RDP: begin
        state_d = S_WTP;
      end
      S_WTP: begin
        cmd_o.cur_load = 1'b1;
        cmd_o.q_init   = 1'b1;
        state_d        = sts_i.last_p ? S_EMIT : S_RDQ;
      end
      S_RDQ: begin
        cmd_o.rd_q_sel = 1'b1;
        state_d        = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        if (sts_i.last_q) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.q_inc = 1'b1;
          state_d     = S_RDQ;
        end
      end
      S_EMIT: begin
        cmd_o.out_load = 1'b1;
        out_valid_d    = 1'b1;
        state_d        = S_OUT;
      end
      S_OUT: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          if (sts_i.last_p) begin
            cmd_o.done = 1'b1;
            state_d    = S_LOAD;
          end else begin
            cmd_o.p_inc = 1'b1;
            state_d     = S_RDP;
          end
        end
      end
      default: begin
        state_d     = S_LOAD;
        out_valid_d = 1'b0;
      end
    endcase
  end

  // State and registered valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      out_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_o <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the exchange sorter
// Lists of signed words are fed in through a clocked driver. A built-in
// ascending sorter predicts every returned word, and a clocked monitor checks
// each one. Idle and stall rates on both channels change from phase to phase.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LIST_CAP    = 16;
  localparam int WORD_W      = 32;
  localparam int STALL_LIMIT = 5000;
  localparam int ITEMS_PHASE = 55;
  localparam int SETTLE      = 40;

  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

  // One input word of a list
  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     last;
  } list_word_t;

  // One returned word
  typedef struct packed {
    logic signed [WORD_W-1:0] sorted_value;
    logic                     final_res;
    logic                     overflow;
  } sorted_word_t;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_stall_o;
  logic signed [WORD_W-1:0] value_i        = '0;
  logic                     last_i         = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i    = 1'b0;
  logic signed [WORD_W-1:0] sorted_value_o;
  logic                     final_res_o;
  logic                     overflow_o;

  list_word_t   pending_words[$];
  sorted_word_t sorted_expected[$];

  // Predictor state: words of the list being collected
  logic signed [WORD_W-1:0] held_values[LIST_CAP];
  int                       held_count   = 0;
  logic                     held_dropped = 1'b0;

  int mismatch_count     = 0;
  int quiet_cycles       = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;

  exchange_sorter #(
    .MAX_LEN   (LIST_CAP),
    .DATA_WIDTH(WORD_W)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sorted_value_o(sorted_value_o),
    .final_res_o   (final_res_o),
    .overflow_o    (overflow_o)
  );

  // Clock, period 8
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Take one accepted word into the predictor; on the last word, sort the
  // held list ascending and queue the words it must return
  function automatic void absorb_word(input list_word_t w);
    logic signed [WORD_W-1:0] ordered[LIST_CAP];
    logic signed [WORD_W-1:0] swap_tmp;
    sorted_word_t             res;
    int                       p;
    int                       q;
    if (held_count < LIST_CAP) begin
      held_values[held_count] = w.value;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (!w.last) return;
    ordered = held_values;
    for (p = 0; p + 1 < held_count; p++) begin
      for (q = p + 1; q < held_count; q++) begin
        if (ordered[q] < ordered[p]) begin
          swap_tmp   = ordered[p];
          ordered[p] = ordered[q];
          ordered[q] = swap_tmp;
        end
      end
    end
    for (p = 0; p < held_count; p++) begin
      res.sorted_value = ordered[p];
      res.final_res    = (p == held_count - 1);
      res.overflow     = held_dropped;
      sorted_expected.push_back(res);
    end
    held_count   = 0;
    held_dropped = 1'b0;
  endfunction

  // Random word for a list; style 1 favours a narrow range so that
  // duplicates are common, style 2 favours the extremes
  function automatic logic signed [WORD_W-1:0] pick_value(input int style);
    logic signed [WORD_W-1:0] v;
    int                       sel;
    sel = $urandom_range(0, 3);
    v   = $urandom();
    if (style == 1 && sel != 0) begin
      v = $signed($urandom_range(0, 16)) - 8;
    end else if (style == 2 && sel != 0) begin
      case ($urandom_range(0, 4))
        0: v = WORD_MAX;
        1: v = WORD_MIN;
        2: v = -1;
        3: v = 0;
        default: v = 1;
      endcase
    end
    return v;
  endfunction

  task automatic push_word(input logic signed [WORD_W-1:0] v, input logic is_last);
    list_word_t w;
    w.value = v;
    w.last  = is_last;
    pending_words.push_back(w);
  endtask

  task automatic queue_list(input int len, input int style);
    int k;
    for (k = 0; k < len; k++) push_word(pick_value(style), k == len - 1);
  endtask

  // Wait until every queued word is taken and every result has come back
  task automatic drain_phase();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || sorted_expected.size() != 0);
  endtask

  // Input driver: pops the accepted word, then offers the next one or idles
  always @(posedge clk_i) begin : drive_words
    list_word_t w;
    logic       taken;
    taken = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        w = pending_words.pop_front();
        absorb_word(w);
        taken = 1'b1;
      end
      if (in_valid_i && !taken) begin
        // stalled: hold the word as it is
      end else if (pending_words.size() != 0 &&
                   $urandom_range(0, 99) >= sender_idle_pct) begin
        in_valid_i <= 1'b1;
        value_i    <= pending_words[0].value;
        last_i     <= pending_words[0].last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output monitor: random stall, and check each accepted word in order
  always @(posedge clk_i) begin : check_words
    sorted_word_t exp;
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct);
      if (out_valid_o && !out_stall_i) begin
        if (sorted_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected word: value %0d final %0b overflow %0b",
                     sorted_value_o, final_res_o, overflow_o);
        end else begin
          exp = sorted_expected.pop_front();
          if (sorted_value_o !== exp.sorted_value || final_res_o !== exp.final_res ||
              overflow_o !== exp.overflow) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp value %0d final %0b overflow %0b, got %0d %0b %0b",
                       exp.sorted_value, exp.final_res, exp.overflow,
                       sorted_value_o, final_res_o, overflow_o);
          end
        end
      end
    end
  end

  // Watchdog: too long with no word moving on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Stimulus: reset, directed lists, then random lists phase by phase
  initial begin : stimulus
    int idle_by_phase[4];
    int stall_by_phase[4];
    int phase;
    int fed;
    int len;
    int style;
    int pick;
    idle_by_phase  = '{0, 72, 0, 19};
    stall_by_phase = '{0, 0, 72, 19};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    // single word list, most negative value
    push_word(WORD_MIN, 1'b1);
    // equal values are kept, not reordered away
    push_word(7, 1'b0);
    push_word(-7, 1'b0);
    push_word(7, 1'b1);
    // full store with extremes, then two more words dropped, the last among them
    push_word(WORD_MAX, 1'b0);
    push_word(WORD_MIN, 1'b0);
    push_word(-1, 1'b0);
    push_word(0, 1'b0);
    push_word(1, 1'b0);
    push_word(WORD_MAX, 1'b0);
    push_word(WORD_MIN, 1'b0);
    push_word(-1, 1'b0);
    push_word(32'sh5555_5555, 1'b0);
    push_word(32'shAAAA_AAAA, 1'b0);
    push_word(2, 1'b0);
    push_word(-2, 1'b0);
    push_word(0, 1'b0);
    push_word(1000, 1'b0);
    push_word(-1000, 1'b0);
    push_word(42, 1'b0);
    push_word(77, 1'b0);
    push_word(-77, 1'b1);
    drain_phase();

    for (phase = 0; phase < 4; phase++) begin
      sender_idle_pct    <= idle_by_phase[phase];
      receiver_stall_pct <= stall_by_phase[phase];
      fed = 0;
      while (fed < ITEMS_PHASE) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)      len = $urandom_range(LIST_CAP + 1, LIST_CAP + 5);
        else if (pick == 1) len = LIST_CAP;
        else if (pick == 2) len = 1;
        else                len = $urandom_range(2, LIST_CAP - 1);
        style = $urandom_range(0, 2);
        queue_list(len, style);
        fed += len;
      end
      drain_phase();
    end

    repeat (SETTLE) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
